// ===== rtl/core/grsc_pkg.sv =====
// Shared types and constants of the grid ray shadow caster.
`timescale 1ns / 1ps
package grsc_pkg;

	localparam int DIVD_W = 31;
	localparam int DIVS_W = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [23:0] DELTA_SAT = 24'hFF_FFFF;
	localparam logic [16:0] ONE_Q16 = 17'h1_0000;
	localparam logic [DIVD_W-1:0] RECIP_DIVIDEND = DIVD_W'(1) << 30;
	localparam logic [DIVD_W-1:0] RANGE_DIVIDEND = DIVD_W'(1) << 24;

	localparam logic [CFG_INDEX_W-1:0] CFG_MAP_COLS = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAP_ROWS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEPS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FALLOFF_RANGE = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SHADOW_STEP = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ALPHA = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_USED = 3'd6;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_TRACE = 2'd1,
		ACT_READ = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		DIV_DELTA_X = 2'd0,
		DIV_DELTA_Y = 2'd1,
		DIV_RANGE = 2'd2
	} div_phase_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_ADDR,
		S_WRITE,
		S_READ,
		S_READ_DATA,
		S_DIV_START,
		S_DIV_WAIT,
		S_STEP,
		S_CELL_ADDR,
		S_CELL_RD,
		S_CELL,
		S_MUL1,
		S_MUL2,
		S_MUL3,
		S_ALPHA,
		S_RESP
	} state_t;

endpackage

// ===== rtl/core/grsc_item_if.sv =====
// Channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface grsc_item_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic signed [7:0] pos_x;
	logic signed [7:0] pos_y;
	logic [2:0] layer_sel;
	logic [7:0] occupied_mask;
	logic signed [15:0] dir_x;
	logic signed [15:0] dir_y;

	modport source (output valid, action, pos_x, pos_y, layer_sel, occupied_mask, dir_x,
		dir_y, input ready);
	modport sink (input valid, action, pos_x, pos_y, layer_sel, occupied_mask, dir_x,
		dir_y, output ready);
endinterface

interface grsc_result_if;
	logic valid;
	logic ready;
	logic [7:0] alpha_value;
	logic [7:0] steps_taken;
	logic [2:0] blocker_layer;
	logic [7:0] shadow_writes;
	logic coord_error;

	modport source (output valid, alpha_value, steps_taken, blocker_layer, shadow_writes,
		coord_error, input ready);
	modport sink (input valid, alpha_value, steps_taken, blocker_layer, shadow_writes,
		coord_error, output ready);
endinterface

// ===== rtl/core/grsc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module grsc_div import grsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic done,
	output logic [DIVD_W-1:0] quotient,
	output logic [DIVS_W-1:0] remainder
);
	localparam int CNT_W = $clog2(DIVD_W);

	logic busy_q, done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] dvd_q, quo_q;
	logic [DIVS_W-1:0] dvs_q, rem_q;
	logic [DIVS_W:0] trial, diff;
	logic fits;

	assign trial = {rem_q, dvd_q[DIVD_W-1]};
	assign fits = trial >= {1'b0, dvs_q};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIVD_W-2:0], 1'b0};
			quo_q <= {quo_q[DIVD_W-2:0], fits};
			rem_q <= fits ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule

// ===== rtl/core/grsc_store.sv =====
// Tile occupancy and shadow alpha memories, one row per tile.
`timescale 1ns / 1ps
module grsc_store #(
	parameter int TILES = 4096,
	parameter int LAYERS = 8
) (
	input  logic clk,
	input  logic [$clog2(TILES)-1:0] addr,
	input  logic occ_we,
	input  logic [LAYERS-1:0] occ_wdata,
	input  logic alpha_we,
	input  logic [LAYERS*8-1:0] alpha_wdata,
	output logic [LAYERS-1:0] occ_rdata,
	output logic [LAYERS*8-1:0] alpha_rdata
);
	logic [LAYERS-1:0] occ_mem [TILES];
	logic [LAYERS*8-1:0] alpha_mem [TILES];

	always_ff @(posedge clk) begin
		if (occ_we)
			occ_mem[addr] <= occ_wdata;
		occ_rdata <= occ_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (alpha_we)
			alpha_mem[addr] <= alpha_wdata;
		alpha_rdata <= alpha_mem[addr];
	end
endmodule

// ===== rtl/core/grid_ray_shadow_caster_unit.sv =====
// Top level of the grid ray shadow caster: sequencer, datapath and config registers.
// A write passes S_ADDR and S_WRITE, a read S_ADDR, S_READ and S_READ_DATA, an unused
// action S_ADDR only; a trace runs three shared-divider passes, then per step S_STEP
// and S_CELL_ADDR, in-map also S_CELL_RD and S_CELL, past the blocker S_MUL1 to S_ALPHA.
// One item at a time; the result register holds until taken.
// After reset a clearing pass over all MAP_SIDE*MAP_SIDE tiles zeroes both memories.
`timescale 1ns / 1ps
module grid_ray_shadow_caster_unit import grsc_pkg::*; #(
	parameter int MAP_SIDE = 64,
	parameter int LAYER_COUNT = 8,
	parameter int OCCLUSION_LAYER = 4
) (
	input  logic clk,
	input  logic arst_n,
	grsc_item_if.sink item,
	grsc_result_if.source result,
	input  logic cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int TILES = MAP_SIDE * MAP_SIDE;
	localparam int ADDR_W = $clog2(TILES);
	localparam int ROW_W = LAYER_COUNT * 8;

	// configuration
	logic [6:0] map_cols_q, map_rows_q;
	logic [7:0] max_steps_q, max_alpha_q, layer_used_q;
	logic [15:0] falloff_range_q, shadow_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= 7'd64;
			map_rows_q <= 7'd64;
			max_steps_q <= 8'd64;
			falloff_range_q <= 16'd2048;
			shadow_step_q <= 16'd6554;
			max_alpha_q <= 8'd255;
			layer_used_q <= 8'd255;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_MAP_COLS: map_cols_q <= cfg_data[6:0];
				CFG_MAP_ROWS: map_rows_q <= cfg_data[6:0];
				CFG_MAX_STEPS: max_steps_q <= cfg_data[7:0];
				CFG_FALLOFF_RANGE: falloff_range_q <= cfg_data;
				CFG_SHADOW_STEP: shadow_step_q <= cfg_data;
				CFG_MAX_ALPHA: max_alpha_q <= cfg_data[7:0];
				CFG_LAYER_USED: layer_used_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	state_t state_q, state_d;
	logic [ADDR_W-1:0] clr_q;
	div_phase_t phase_q;

	// item and walk registers
	logic [1:0] action_q;
	logic [2:0] sel_q;
	logic [LAYER_COUNT-1:0] occ_in_q;
	logic signed [15:0] dx_q, dy_q;
	logic signed [9:0] px_q, py_q;
	logic [ADDR_W-1:0] addr_q;
	logic [23:0] tdx_q, tdy_q, rq0_q;
	logic [15:0] rr0_q, rem_acc_q;
	logic [31:0] tmx_q, tmy_q;
	logic [25:0] q_acc_q;
	logic [16:0] rf_q, dark_q;
	logic [32:0] p1_q;
	logic [7:0] v_q;
	logic [2:0] mult_q, blocker_q;
	logic [LAYER_COUNT-1:0] occ_q;
	logic [ROW_W-1:0] row_q;
	logic [7:0] steps_q, writes_q, alpha_out_q;
	logic cerr_q;

	// address of the current position
	logic [6:0] cols_eff, rows_eff;
	logic inmap_c;
	logic [ADDR_W-1:0] addr_c;
	logic [13:0] lin_c;

	assign cols_eff = (32'(map_cols_q) > MAP_SIDE) ? 7'(MAP_SIDE) : map_cols_q;
	assign rows_eff = (32'(map_rows_q) > MAP_SIDE) ? 7'(MAP_SIDE) : map_rows_q;
	assign inmap_c = !px_q[9] && !py_q[9] && (px_q < $signed({3'b000, cols_eff}))
		&& (py_q < $signed({3'b000, rows_eff}));
	assign lin_c = 14'({7'd0, py_q[6:0]} * {7'd0, cols_eff}) + {7'd0, px_q[6:0]};
	assign addr_c = ADDR_W'(lin_c);

	// direction
	logic [15:0] mag_x, mag_y;
	logic dx_pos, dy_pos, dx_nz, dy_nz, step_x;
	assign mag_x = dx_q[15] ? 16'(~dx_q + 16'sd1) : dx_q;
	assign mag_y = dy_q[15] ? 16'(~dy_q + 16'sd1) : dy_q;
	assign dx_nz = dx_q != 16'sd0;
	assign dy_nz = dy_q != 16'sd0;
	assign dx_pos = dx_nz && !dx_q[15];
	assign dy_pos = dy_nz && !dy_q[15];
	assign step_x = dx_nz && (!dy_nz || tmx_q < tmy_q);

	// shared divider
	logic div_start, div_done;
	logic [DIVD_W-1:0] div_dvd, div_quo;
	logic [DIVS_W-1:0] div_dvs, div_rem;
	logic [23:0] delta_c;
	logic [15:0] phase_mag;

	assign div_start = state_q == S_DIV_START;
	always_comb begin
		unique case (phase_q)
			DIV_DELTA_X: begin div_dvd = RECIP_DIVIDEND; div_dvs = mag_x; end
			DIV_DELTA_Y: begin div_dvd = RECIP_DIVIDEND; div_dvs = mag_y; end
			default: begin div_dvd = RANGE_DIVIDEND; div_dvs = falloff_range_q; end
		endcase
	end
	assign phase_mag = (phase_q == DIV_DELTA_X) ? mag_x : mag_y;
	assign delta_c = (phase_mag == 16'd0 || div_quo > DIVD_W'(DELTA_SAT)) ? DELTA_SAT
		: div_quo[23:0];

	grsc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dvd),
		.divisor(div_dvs), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	// memories
	logic [ADDR_W-1:0] mem_addr;
	logic occ_we, alpha_we;
	logic [LAYER_COUNT-1:0] occ_wdata, occ_rdata;
	logic [ROW_W-1:0] alpha_wdata, alpha_rdata, row_new;

	assign mem_addr = (state_q == S_CLEAR) ? clr_q : addr_q;

	grsc_store #(.TILES(TILES), .LAYERS(LAYER_COUNT)) u_store (
		.clk(clk), .addr(mem_addr), .occ_we(occ_we), .occ_wdata(occ_wdata),
		.alpha_we(alpha_we), .alpha_wdata(alpha_wdata), .occ_rdata(occ_rdata),
		.alpha_rdata(alpha_rdata)
	);

	// layer searches
	logic [2:0] blk_c, low_l;
	logic low_hit;
	logic [7:0] old_b, rd_byte;
	always_comb begin
		blk_c = '0;
		low_l = '0;
		low_hit = 1'b0;
		old_b = '0;
		rd_byte = '0;
		row_new = row_q;
		for (int l = 0; l < LAYER_COUNT; l++) begin
			if (l >= OCCLUSION_LAYER && layer_used_q[l] && occ_rdata[l])
				blk_c = 3'(l);
			if (l < 32'(blocker_q) && layer_used_q[l] && occ_q[l]) begin
				low_hit = 1'b1;
				low_l = 3'(l);
			end
		end
		for (int l = 0; l < LAYER_COUNT; l++) begin
			if (3'(l) == low_l) begin
				old_b = row_q[l*8 +: 8];
				row_new[l*8 +: 8] = v_q;
			end
			if (3'(l) == sel_q)
				rd_byte = alpha_rdata[l*8 +: 8];
		end
	end

	// range factor: running quotient of n * 2^24 / falloff range
	logic [16:0] rsum_c;
	logic rcarry_c;
	logic [25:0] q_new_c;
	logic [16:0] rf_c;
	assign rsum_c = {1'b0, rem_acc_q} + {1'b0, rr0_q};
	assign rcarry_c = rsum_c >= {1'b0, falloff_range_q};
	assign q_new_c = q_acc_q + {2'b00, rq0_q} + {25'd0, rcarry_c};
	assign rf_c = (falloff_range_q == 16'd0 || q_new_c >= {9'd0, ONE_Q16}) ? 17'd0
		: 17'({9'd0, ONE_Q16} - q_new_c);

	logic [35:0] pm_c;
	logic [20:0] dsum_c;
	logic [24:0] va_c;
	assign pm_c = {3'b000, p1_q} * {33'd0, mult_q};
	assign dsum_c = {4'd0, dark_q} + {1'b0, pm_c[35:16]};
	assign va_c = dark_q * max_alpha_q;

	logic accept;
	assign accept = item.valid && item.ready;
	assign item.ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		occ_we = 1'b0;
		alpha_we = 1'b0;
		occ_wdata = occ_in_q;
		alpha_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				occ_we = 1'b1;
				occ_wdata = '0;
				alpha_we = 1'b1;
				if (32'(clr_q) == TILES - 1)
					state_d = S_IDLE;
			end
			S_IDLE: if (accept) state_d = S_ADDR;
			S_ADDR: begin
				case (action_q)
					ACT_WRITE: state_d = S_WRITE;
					ACT_READ: state_d = S_READ;
					ACT_TRACE: state_d = S_DIV_START;
					default: state_d = S_RESP;
				endcase
			end
			S_WRITE: begin
				occ_we = !cerr_q;
				alpha_we = !cerr_q;
				state_d = S_RESP;
			end
			S_READ: state_d = S_READ_DATA;
			S_READ_DATA: state_d = S_RESP;
			S_DIV_START: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_done)
					state_d = (phase_q == DIV_RANGE) ? S_STEP : S_DIV_START;
			end
			S_STEP: state_d = (steps_q >= max_steps_q) ? S_RESP : S_CELL_ADDR;
			S_CELL_ADDR: state_d = inmap_c ? S_CELL_RD : S_STEP;
			S_CELL_RD: state_d = S_CELL;
			S_CELL: state_d = (blocker_q == '0) ? S_STEP : S_MUL1;
			S_MUL1: state_d = S_MUL2;
			S_MUL2: state_d = S_MUL3;
			S_MUL3: state_d = S_ALPHA;
			S_ALPHA: begin
				alpha_we = low_hit && (v_q > old_b);
				alpha_wdata = row_new;
				state_d = (rf_q == '0) ? S_RESP : S_STEP;
			end
			S_RESP: if (result.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				action_q <= item.action;
				px_q <= 10'(item.pos_x);
				py_q <= 10'(item.pos_y);
				sel_q <= item.layer_sel;
				occ_in_q <= item.occupied_mask[LAYER_COUNT-1:0];
				dx_q <= item.dir_x;
				dy_q <= item.dir_y;
				steps_q <= '0;
				writes_q <= '0;
				blocker_q <= '0;
				alpha_out_q <= '0;
				cerr_q <= 1'b0;
				phase_q <= DIV_DELTA_X;
			end
			S_ADDR: begin
				addr_q <= addr_c;
				cerr_q <= (action_q == ACT_WRITE || action_q == ACT_READ) && !inmap_c;
			end
			S_READ_DATA: begin
				if (!cerr_q && 32'(sel_q) < LAYER_COUNT)
					alpha_out_q <= rd_byte;
			end
			S_DIV_WAIT: begin
				if (div_done) begin
					case (phase_q)
						DIV_DELTA_X: begin
							tdx_q <= delta_c;
							tmx_q <= dx_pos ? {8'd0, delta_c} : 32'd0;
							phase_q <= DIV_DELTA_Y;
						end
						DIV_DELTA_Y: begin
							tdy_q <= delta_c;
							tmy_q <= dy_pos ? {8'd0, delta_c} : 32'd0;
							phase_q <= DIV_RANGE;
						end
						default: begin
							// saturate a quotient past 24 bits; any such value ends the falloff
							rq0_q <= div_quo[24] ? 24'hFF_FFFF : div_quo[23:0];
							rr0_q <= div_rem;
						end
					endcase
				end
			end
			S_STEP: begin
				if (steps_q < max_steps_q) begin
					steps_q <= steps_q + 1'b1;
					if (step_x) begin
						tmx_q <= tmx_q + {8'd0, tdx_q};
						px_q <= dx_pos ? px_q + 10'sd1 : px_q - 10'sd1;
					end else begin
						tmy_q <= tmy_q + {8'd0, tdy_q};
						py_q <= dy_pos ? py_q + 10'sd1 : py_q - 10'sd1;
					end
				end
			end
			S_CELL_ADDR: addr_q <= addr_c;
			S_CELL: begin
				occ_q <= occ_rdata;
				row_q <= alpha_rdata;
				if (blocker_q == '0) begin
					if (blk_c != '0) begin
						blocker_q <= blk_c;
						mult_q <= 3'(32'(blk_c) - OCCLUSION_LAYER + 1);
						dark_q <= '0;
						q_acc_q <= '0;
						rem_acc_q <= '0;
					end
				end else begin
					q_acc_q <= q_new_c;
					rem_acc_q <= rcarry_c ? 16'(rsum_c - {1'b0, falloff_range_q})
						: rsum_c[15:0];
					rf_q <= rf_c;
				end
			end
			S_MUL1: p1_q <= shadow_step_q * rf_q;
			// saturate darkness at 1.0
			S_MUL2: dark_q <= (dsum_c > {4'd0, ONE_Q16}) ? ONE_Q16 : dsum_c[16:0];
			S_MUL3: v_q <= va_c[23:16];
			S_ALPHA: begin
				if (low_hit && (v_q > old_b) && writes_q != 8'hFF)
					writes_q <= writes_q + 1'b1;
			end
			default: ;
		endcase
	end

	assign result.valid = state_q == S_RESP;
	assign result.alpha_value = alpha_out_q;
	assign result.steps_taken = steps_q;
	assign result.blocker_layer = blocker_q;
	assign result.shadow_writes = writes_q;
	assign result.coord_error = cerr_q;
endmodule
